>>> sv/pn3e_pkg.sv
// pn3e_pkg: shared types and constants for the 3d gradient noise evaluator
// no dependencies; used by pn3e_fade and the top level by scoped names

package pn3e_pkg;

	// permutation table geometry
	localparam int PERM_W     = 8;
	localparam int PERM_DEPTH = 256;
	localparam int TABLE_AW   = 8;

	// result word
	localparam int NOISE_W   = 16;
	localparam int NOISE_MAX = 32767;
	localparam int NOISE_MIN = -32768;

	// quintic fade coefficients: 6t^5 - 15t^4 + 10t^3
	localparam int FADE_C6  = 6;
	localparam int FADE_C15 = 15;
	localparam int FADE_C10 = 10;

	// fade unit controls, one step per cycle
	typedef struct packed {
		logic sq;    // r = t*t
		logic poly;  // r = 6r - 15t + 10
		logic mul;   // r = r*t
	} fade_ctl_t;

endpackage

>>> sv/pn3e_ram.sv
// pn3e_ram: generic synchronous ram, one write port and two registered read ports
// no dependencies

module pn3e_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> sv/pn3e_fade.sv
// pn3e_fade: quintic fade of one unsigned fraction, one multiply per step
// depends on pn3e_pkg (fade_ctl_t, fade coefficients)

module pn3e_fade #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  pn3e_pkg::fade_ctl_t   ctl,
	input  logic [FRAC_BITS-1:0]  t,
	output logic [FRAC_BITS:0]    fade
);

	localparam int RW = FRAC_BITS + 4;
	localparam int PW = RW + FRAC_BITS;
	localparam int QW = FRAC_BITS + 5;

	logic [RW-1:0] r_q;
	logic [RW-1:0] mult_a;
	logic [PW-1:0] prod;
	logic [QW-1:0] q_wide;

	// shared multiplier: t*t on the first step, r*t afterwards
	assign mult_a = ctl.sq ? RW'(t) : r_q;
	assign prod   = PW'(mult_a) * PW'(t);

	// polynomial 6*t2 + 10*one - 15*t, always positive
	assign q_wide = QW'(r_q) * QW'(pn3e_pkg::FADE_C6)
		+ (QW'(pn3e_pkg::FADE_C10) << FRAC_BITS)
		- QW'(t) * QW'(pn3e_pkg::FADE_C15);

	always_ff @(posedge clk) begin
		if (ctl.sq || ctl.mul) begin
			r_q <= prod[PW-1:FRAC_BITS];
		end else if (ctl.poly) begin
			r_q <= q_wide[RW-1:0];
		end
	end

	assign fade = r_q[FRAC_BITS:0];

endmodule

>>> sv/pn3e_grad.sv
// pn3e_grad: dot product of a corner offset with one of twelve gradient directions
// no dependencies

module pn3e_grad #(
	parameter int FRAC_BITS = 16
) (
	input  logic [3:0]                 hash,
	input  logic signed [FRAC_BITS:0]  x,
	input  logic signed [FRAC_BITS:0]  y,
	input  logic signed [FRAC_BITS:0]  z,
	output logic signed [FRAC_BITS+2:0] grad
);

	localparam int VW = FRAC_BITS + 3;
	localparam logic [3:0] HASH_XA = 4'd12;
	localparam logic [3:0] HASH_XB = 4'd14;

	logic signed [VW-1:0] xe, ye, ze, u, v, us, vs;

	always_comb begin
		xe = VW'(x);
		ye = VW'(y);
		ze = VW'(z);
		// first term: x for the low eight hashes, y otherwise
		u = hash[3] ? ye : xe;
		// second term: y for the low four, x for two special hashes, else z
		if (hash[3:2] == 2'b00) begin
			v = ye;
		end else if (hash inside {HASH_XA, HASH_XB}) begin
			v = xe;
		end else begin
			v = ze;
		end
		us = hash[0] ? -u : u;
		vs = hash[1] ? -v : v;
		grad = us + vs;
	end

endmodule

>>> sv/pn3e_lerp.sv
// pn3e_lerp: two-stage linear interpolation a + floor(f*(b-a) / 2^F)
// no dependencies; takes one operand set per cycle while hold is low, result registered in stage 2

module pn3e_lerp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        hold,
	input  logic [FRAC_BITS:0]          f,
	input  logic signed [FRAC_BITS+2:0] a,
	input  logic signed [FRAC_BITS+2:0] b,
	output logic signed [FRAC_BITS+2:0] result
);

	localparam int VW = FRAC_BITS + 3;
	localparam int DW = VW + 1;
	localparam int PW = FRAC_BITS + 2 + DW;

	logic signed [DW-1:0]            diff;
	logic signed [FRAC_BITS+1:0]     f_s;
	logic signed [PW-1:0]            prod_s1;
	logic signed [VW-1:0]            base_s1;
	logic signed [PW-1:0]            scaled;
	logic signed [VW-1:0]            result_s2;

	assign diff = DW'(b) - DW'(a);
	assign f_s  = signed'({1'b0, f});

	// stage 1: product; hold freezes both stages
	always_ff @(posedge clk) begin
		if (!hold) begin
			prod_s1 <= PW'(f_s) * PW'(diff);
			base_s1 <= a;
		end
	end

	// stage 2: floor shift and add; the true sum always fits VW bits
	assign scaled = prod_s1 >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (!hold) begin
			result_s2 <= base_s1 + signed'(scaled[VW-1:0]);
		end
	end

	assign result = result_s2;

endmodule

>>> sv/perlin_noise_3d_eval_unit.sv
// perlin_noise_3d_eval_unit: top level of the 3d improved gradient noise evaluator
// depends on pn3e_pkg, pn3e_ram, pn3e_fade, pn3e_grad, pn3e_lerp
//
// Usage:
//   Input channel (req_valid/req_ready) carries one word per request.
//   req_type 0 writes table_value into permutation entry table_index; it is
//   taken without making the unit busy and produces no result. Every entry must be written
//   before the first evaluation. req_type 1 evaluates the noise at the
//   fixed-point point coord_x/y/z and produces one noise_value word on the
//   output channel (noise_valid/noise_ready).
//   An evaluation keeps the unit busy from acceptance until its result is loaded
//   into the output register, so no new point is taken while one is in flight. The
//   busy span is set by the three dependent levels of permutation reads on the two
//   read ports of the table (seven read steps) followed by seven interpolations sharing one
//   two-stage multiplier; the fades run on their own multipliers during the reads.
//   The result sits in an output register; the next request is taken while it
//   waits. If the receiver stalls and a second evaluation finishes, that one
//   holds in its last step until the output register frees.
//   Reset clears the control state and the output valid; the table contents
//   are not cleared.

module perlin_noise_3d_eval_unit #(
	parameter int FRAC_BITS     = 16,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  logic                                 req_type,
	input  logic [pn3e_pkg::TABLE_AW-1:0]        table_index,
	input  logic [pn3e_pkg::PERM_W-1:0]          table_value,
	input  logic signed [31:0]                   coord_x,
	input  logic signed [31:0]                   coord_y,
	input  logic signed [31:0]                   coord_z,
	output logic                                 noise_valid,
	input  logic                                 noise_ready,
	output logic signed [pn3e_pkg::NOISE_W-1:0]  noise_value
);

	localparam int VW = FRAC_BITS + 3;
	localparam int AW = pn3e_pkg::TABLE_AW;
	localparam int MW = (FRAC_BITS > OUT_FRAC_BITS) ? FRAC_BITS : OUT_FRAC_BITS;
	localparam int CW = (MW + 4 > 17) ? MW + 4 : 17;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_EVAL  = 1'b1;

	// sequencer steps
	localparam logic [3:0] STEP_CELL    = 4'd0;
	localparam logic [3:0] STEP_ROW_A   = 4'd1;
	localparam logic [3:0] STEP_ROW_B   = 4'd2;
	localparam logic [3:0] STEP_CORNER0 = 4'd3;
	localparam logic [3:0] STEP_CORNER1 = 4'd4;
	localparam logic [3:0] STEP_CORNER2 = 4'd5;
	localparam logic [3:0] STEP_CORNER3 = 4'd6;
	localparam logic [3:0] STEP_LERP3   = 4'd7;
	localparam logic [3:0] STEP_LERP4   = 4'd8;
	localparam logic [3:0] STEP_MIX_Y0  = 4'd9;
	localparam logic [3:0] STEP_MIX_Y1  = 4'd10;
	localparam logic [3:0] STEP_HOLD_M1 = 4'd11;
	localparam logic [3:0] STEP_MIX_Z   = 4'd12;
	localparam logic [3:0] STEP_WAIT    = 4'd13;
	localparam logic [3:0] STEP_OUT     = 4'd14;

	localparam logic [AW-1:0] IDX_ONE = AW'(1);

	logic                  busy_q;
	logic [3:0]            step_q;
	logic                  noise_valid_q;
	logic signed [pn3e_pkg::NOISE_W-1:0] noise_q;

	logic                  req_fire;
	logic                  eval_fire;
	logic                  table_we;
	logic                  out_load;
	logic                  lerp_hold;

	logic [AW-1:0]         cx_q, cy_q, cz_q;
	logic [FRAC_BITS-1:0]  tx_q, ty_q, tz_q;
	logic [AW-1:0]         b_q, aa_q, ab_q, ba_q, bb_q;

	logic [AW-1:0]         raddr_a, raddr_b;
	logic [pn3e_pkg::PERM_W-1:0] rd_a, rd_b;
	logic [AW-1:0]         row_a_idx, row_b_idx, col_a_idx, col_b_idx;

	pn3e_pkg::fade_ctl_t   fade_ctl;
	logic [FRAC_BITS:0]    fade_u, fade_v, fade_w;

	logic                  y_far, z_far;
	logic signed [VW-1:0]  grad_a, grad_b;
	logic signed [VW-1:0]  ga_q, gb_q;

	logic [FRAC_BITS:0]    lerp_f;
	logic signed [VW-1:0]  lerp_a, lerp_b, lerp_res;
	logic signed [VW-1:0]  l1_q, l2_q, l3_q, m1_q;

	logic signed [CW-1:0]  res_ext, conv;
	logic signed [pn3e_pkg::NOISE_W-1:0] noise_d;

	// handshake
	assign req_ready = !busy_q;
	assign req_fire  = req_valid && req_ready;
	assign eval_fire = req_fire && (req_type == REQ_EVAL);
	assign table_we  = req_fire && (req_type == REQ_WRITE);
	assign out_load  = busy_q && (step_q == STEP_OUT) && (!noise_valid_q || noise_ready);

	// keep the final interpolation while the result waits for the output register
	assign lerp_hold = busy_q && (step_q == STEP_OUT) && !out_load;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_CELL;
		end else if (eval_fire) begin
			busy_q <= 1'b1;
			step_q <= STEP_CELL;
		end else if (busy_q) begin
			if (step_q == STEP_OUT) begin
				if (out_load) begin
					busy_q <= 1'b0;
				end
			end else begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	// point split into lattice cell and fraction
	always_ff @(posedge clk) begin
		if (eval_fire) begin
			cx_q <= coord_x[FRAC_BITS +: AW];
			cy_q <= coord_y[FRAC_BITS +: AW];
			cz_q <= coord_z[FRAC_BITS +: AW];
			tx_q <= coord_x[FRAC_BITS-1:0];
			ty_q <= coord_y[FRAC_BITS-1:0];
			tz_q <= coord_z[FRAC_BITS-1:0];
		end
	end

	// permutation table
	pn3e_ram #(
		.WIDTH (pn3e_pkg::PERM_W),
		.DEPTH (pn3e_pkg::PERM_DEPTH)
	) u_perm (
		.clk     (clk),
		.we      (table_we),
		.waddr   (table_index),
		.wdata   (table_value),
		.raddr_a (raddr_a),
		.rdata_a (rd_a),
		.raddr_b (raddr_b),
		.rdata_b (rd_b)
	);

	// hash chain sums, all modulo 256
	assign row_a_idx = rd_a + cy_q;
	assign row_b_idx = rd_b + cy_q;
	assign col_a_idx = rd_a + cz_q;
	assign col_b_idx = rd_b + cz_q;

	// read address schedule
	always_comb begin
		case (step_q)
			STEP_CELL: begin
				raddr_a = cx_q;
				raddr_b = cx_q + IDX_ONE;
			end
			STEP_ROW_A: begin
				raddr_a = row_a_idx;
				raddr_b = row_a_idx + IDX_ONE;
			end
			STEP_ROW_B: begin
				raddr_a = b_q;
				raddr_b = b_q + IDX_ONE;
			end
			STEP_CORNER0: begin
				raddr_a = aa_q;
				raddr_b = col_a_idx;
			end
			STEP_CORNER1: begin
				raddr_a = ab_q;
				raddr_b = bb_q;
			end
			STEP_CORNER2: begin
				raddr_a = aa_q + IDX_ONE;
				raddr_b = ba_q + IDX_ONE;
			end
			STEP_CORNER3: begin
				raddr_a = ab_q + IDX_ONE;
				raddr_b = bb_q + IDX_ONE;
			end
			default: begin
				raddr_a = cx_q;
				raddr_b = cx_q;
			end
		endcase
	end

	// hash registers between read levels
	always_ff @(posedge clk) begin
		if (step_q == STEP_ROW_A) begin
			b_q <= row_b_idx;
		end
		if (step_q == STEP_ROW_B) begin
			aa_q <= col_a_idx;
			ab_q <= col_b_idx;
		end
		if (step_q == STEP_CORNER0) begin
			ba_q <= col_a_idx;
			bb_q <= col_b_idx;
		end
	end

	// fade units run during the table reads
	always_comb begin
		fade_ctl.sq   = busy_q && (step_q == STEP_CELL);
		fade_ctl.poly = busy_q && (step_q == STEP_ROW_A);
		fade_ctl.mul  = busy_q && ((step_q == STEP_ROW_B) || (step_q == STEP_CORNER0)
			|| (step_q == STEP_CORNER1));
	end

	pn3e_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
		.clk (clk), .ctl (fade_ctl), .t (tx_q), .fade (fade_u)
	);
	pn3e_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
		.clk (clk), .ctl (fade_ctl), .t (ty_q), .fade (fade_v)
	);
	pn3e_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (
		.clk (clk), .ctl (fade_ctl), .t (tz_q), .fade (fade_w)
	);

	// corner of the data now coming back: port a is the near x corner
	assign y_far = (step_q == STEP_CORNER2) || (step_q == STEP_LERP3);
	assign z_far = (step_q == STEP_CORNER3) || (step_q == STEP_LERP3);

	pn3e_grad #(.FRAC_BITS(FRAC_BITS)) u_grad_a (
		.hash (rd_a[3:0]),
		.x    (signed'({1'b0, tx_q})),
		.y    (signed'({y_far, ty_q})),
		.z    (signed'({z_far, tz_q})),
		.grad (grad_a)
	);
	pn3e_grad #(.FRAC_BITS(FRAC_BITS)) u_grad_b (
		.hash (rd_b[3:0]),
		.x    (signed'({1'b1, tx_q})),
		.y    (signed'({y_far, ty_q})),
		.z    (signed'({z_far, tz_q})),
		.grad (grad_b)
	);

	// gradient pair is registered before it feeds the x interpolation
	always_ff @(posedge clk) begin
		ga_q <= grad_a;
		gb_q <= grad_b;
	end

	// interpolation operand schedule
	always_comb begin
		case (step_q)
			STEP_MIX_Y0: begin
				lerp_f = fade_v;
				lerp_a = l1_q;
				lerp_b = l2_q;
			end
			STEP_MIX_Y1: begin
				lerp_f = fade_v;
				lerp_a = l3_q;
				lerp_b = lerp_res;
			end
			STEP_MIX_Z: begin
				lerp_f = fade_w;
				lerp_a = m1_q;
				lerp_b = lerp_res;
			end
			default: begin
				lerp_f = fade_u;
				lerp_a = ga_q;
				lerp_b = gb_q;
			end
		endcase
	end

	pn3e_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
		.clk    (clk),
		.hold   (lerp_hold),
		.f      (lerp_f),
		.a      (lerp_a),
		.b      (lerp_b),
		.result (lerp_res)
	);

	// hold partial interpolations
	always_ff @(posedge clk) begin
		if (step_q == STEP_LERP3) begin
			l1_q <= lerp_res;
		end
		if (step_q == STEP_LERP4) begin
			l2_q <= lerp_res;
		end
		if (step_q == STEP_MIX_Y0) begin
			l3_q <= lerp_res;
		end
		if (step_q == STEP_HOLD_M1) begin
			m1_q <= lerp_res;
		end
	end

	// output scaling
	assign res_ext = CW'(lerp_res);

	generate
		if (OUT_FRAC_BITS < FRAC_BITS) begin : g_round
			localparam int SH = FRAC_BITS - OUT_FRAC_BITS;
			localparam logic signed [CW-1:0] RND = CW'(1) << (SH - 1);
			// round to nearest, ties toward plus infinity
			assign conv = (res_ext + RND) >>> SH;
		end else begin : g_scale
			assign conv = res_ext <<< (OUT_FRAC_BITS - FRAC_BITS);
		end
	endgenerate

	// saturate to the result word
	always_comb begin
		if (conv > CW'(pn3e_pkg::NOISE_MAX)) begin
			noise_d = pn3e_pkg::NOISE_W'(pn3e_pkg::NOISE_MAX);
		end else if (conv < CW'(pn3e_pkg::NOISE_MIN)) begin
			noise_d = pn3e_pkg::NOISE_W'(pn3e_pkg::NOISE_MIN);
		end else begin
			noise_d = conv[pn3e_pkg::NOISE_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_valid_q <= 1'b0;
		end else if (out_load) begin
			noise_valid_q <= 1'b1;
		end else if (noise_ready) begin
			noise_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			noise_q <= noise_d;
		end
	end

	assign noise_valid = noise_valid_q;
	assign noise_value = noise_q;

endmodule
